[rtl/i2a_pkg.sv]
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants for the integer to ASCII printer
// Holds the input and result word types, the cell control struct, the state
// encoding and the digit to character mapping.
// ----------------------------------------------------------------------------
package i2a_pkg;

    // Default field width limit
    localparam int PadLimitDef = 64;

    // Digit cells: enough for 20 decimal digits of a 64-bit magnitude
    localparam int NumCells = 20;
    localparam int NdW      = $clog2(NumCells + 1);

    // Format selector codes
    localparam logic [1:0] FUNC_UDEC = 2'd0;
    localparam logic [1:0] FUNC_HEX  = 2'd1;
    localparam logic [1:0] FUNC_SDEC = 2'd2;

    // Character constants
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A_LC  = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    // Input word
    typedef struct packed {
        logic [1:0]        func;
        logic              word_size;
        logic [63:0]       value;
        logic [7:0]        pad_char;
        logic signed [7:0] pad_width;
    } t_in;

    // Result word
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_res;

    // Per-cycle command shared by all digit cells
    typedef struct packed {
        logic clr;       // clear the digit
        logic bit_shift; // conversion step: adjust, then shift one bit in
        logic dig_shift; // move the whole digit up one cell
        logic dec;       // decimal adjust enabled
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_ALIGN,
        S_LPAD,
        S_SIGN,
        S_DIGIT,
        S_RPAD
    } t_state;

    // One digit (decimal or hex) to its ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = CHAR_ZERO + {4'b0, d};
        end else begin
            r = CHAR_A_LC + {4'b0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

[rtl/integer_to_ascii_padded.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_padded: integer to padded ASCII text, one character a word
// Converts the magnitude bit-serially through a row of digit cells, skips
// leading zero digits, then emits pad, sign, digits and pad one per cycle.
// ----------------------------------------------------------------------------
// Sequence: the 32 (32-bit word) or 64 (64-bit word) magnitude bits are shifted
//   into the cells, Z = 0..19 leading zero digits are skipped at one a cycle,
//   and then the characters follow at one a cycle.
// One number at a time: busy stays high until the last character is put out;
//   a new word is taken as soon as busy drops.
// Reset: synchronous active-low i_rst_n returns to idle and drops o_strobe.
// The receiver cannot stall: each character is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module integer_to_ascii_padded #(
    parameter int PAD_LIMIT = i2a_pkg::PadLimitDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  i2a_pkg::t_in   i_item,
    output logic           busy,
    output logic           o_strobe,
    output i2a_pkg::t_res  o_res
);

    localparam int NCell = i2a_pkg::NumCells;
    localparam int NdW   = i2a_pkg::NdW;
    localparam int PW    = $clog2(PAD_LIMIT + 1);

    // Control state
    i2a_pkg::t_state r_state, n_state;
    logic [5:0]      r_bcnt, n_bcnt;
    logic [NdW-1:0]  r_nd, n_nd;
    logic [PW-1:0]   r_pcnt, n_pcnt;
    logic            r_strobe, n_strobe;

    // Payload held for the current number
    logic [63:0]     r_mag, n_mag;
    logic            r_neg, n_neg;
    logic            r_dec, n_dec;
    logic            r_lpad, n_lpad;
    logic            r_rpad, n_rpad;
    logic [7:0]      r_pc, n_pc;
    logic [PW-1:0]   r_p, n_p;
    i2a_pkg::t_res   r_res, n_res;

    // Cell chain
    i2a_pkg::t_cell_ctl cell_ctl;
    logic [NCell:0]     chain_bit;
    logic [3:0]         chain_dig [NCell+1];

    // Input decode
    logic        in_neg;
    logic [63:0] in_mag;
    logic [7:0]  in_abs;
    logic [PW-1:0] in_p;
    logic [PW-1:0] txt_len;
    logic [PW-1:0] padn;
    logic [3:0]    top_dig;

    // Sign and magnitude of the incoming value
    always_comb begin
        in_neg = (i_item.func == i2a_pkg::FUNC_SDEC) &&
                 (i_item.word_size ? i_item.value[63] : i_item.value[31]);
        if (i_item.word_size) begin
            in_mag = in_neg ? (64'd0 - i_item.value) : i_item.value;
        end else begin
            // Narrow word sits left-justified so that 32 shifts suffice
            in_mag[63:32] = in_neg ? (32'd0 - i_item.value[31:0]) : i_item.value[31:0];
            in_mag[31:0]  = 32'd0;
        end
        in_abs = i_item.pad_width[7] ? (8'd0 - i_item.pad_width) : i_item.pad_width;
        if ({1'b0, in_abs} > 9'(PAD_LIMIT)) begin
            in_p = PW'(PAD_LIMIT);
        end else begin
            in_p = PW'(in_abs);
        end
    end

    // Digit cells, lowest digit in cell 0
    assign chain_bit[0] = r_mag[63];
    assign chain_dig[0] = 4'd0;

    for (genvar gi = 0; gi < NCell; gi++) begin : g_cell
        i2a_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (cell_ctl),
            .i_bit (chain_bit[gi]),
            .i_dig (chain_dig[gi]),
            .o_bit (chain_bit[gi+1]),
            .o_dig (chain_dig[gi+1])
        );
    end

    assign top_dig = chain_dig[NCell];
    assign txt_len = PW'(r_nd) + PW'(r_neg);
    assign padn    = (r_p > txt_len) ? (r_p - txt_len) : '0;

    // Next state and outputs
    always_comb begin
        n_state  = r_state;
        n_bcnt   = r_bcnt;
        n_nd     = r_nd;
        n_pcnt   = r_pcnt;
        n_strobe = 1'b0;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_dec    = r_dec;
        n_lpad   = r_lpad;
        n_rpad   = r_rpad;
        n_pc     = r_pc;
        n_p      = r_p;
        n_res    = r_res;
        cell_ctl = '{clr: 1'b0, bit_shift: 1'b0, dig_shift: 1'b0, dec: r_dec};

        unique case (r_state)
            i2a_pkg::S_IDLE: begin
                if (start) begin
                    n_mag    = in_mag;
                    n_neg    = in_neg;
                    n_dec    = (i_item.func != i2a_pkg::FUNC_HEX);
                    n_lpad   = !i_item.pad_width[7] && (i_item.pad_width != 8'sd0);
                    n_rpad   = i_item.pad_width[7];
                    n_pc     = i_item.pad_char;
                    n_p      = in_p;
                    n_bcnt   = i_item.word_size ? 6'd63 : 6'd31;
                    n_nd     = NdW'(NCell);
                    cell_ctl.clr = 1'b1;
                    n_state  = i2a_pkg::S_CONV;
                end
            end
            i2a_pkg::S_CONV: begin
                // One magnitude bit into the chain per cycle
                cell_ctl.bit_shift = 1'b1;
                n_mag  = {r_mag[62:0], 1'b0};
                n_bcnt = r_bcnt - 6'd1;
                if (r_bcnt == 6'd0) begin
                    n_state = i2a_pkg::S_ALIGN;
                end
            end
            i2a_pkg::S_ALIGN: begin
                // Move leading zeros out of the top cell, keep at least one digit
                if ((top_dig == 4'd0) && (r_nd > NdW'(1))) begin
                    cell_ctl.dig_shift = 1'b1;
                    n_nd = r_nd - NdW'(1);
                end else begin
                    n_pcnt = padn;
                    if (r_lpad && (padn != '0)) begin
                        n_state = i2a_pkg::S_LPAD;
                    end else if (r_neg) begin
                        n_state = i2a_pkg::S_SIGN;
                    end else begin
                        n_state = i2a_pkg::S_DIGIT;
                    end
                end
            end
            i2a_pkg::S_LPAD: begin
                n_strobe = 1'b1;
                n_res    = '{ch: r_pc, last: 1'b0};
                n_pcnt   = r_pcnt - PW'(1);
                if (r_pcnt == PW'(1)) begin
                    n_state = r_neg ? i2a_pkg::S_SIGN : i2a_pkg::S_DIGIT;
                end
            end
            i2a_pkg::S_SIGN: begin
                n_strobe = 1'b1;
                n_res    = '{ch: i2a_pkg::CHAR_MINUS, last: 1'b0};
                n_state  = i2a_pkg::S_DIGIT;
            end
            i2a_pkg::S_DIGIT: begin
                n_strobe = 1'b1;
                cell_ctl.dig_shift = 1'b1;
                n_nd = r_nd - NdW'(1);
                n_res = '{ch: i2a_pkg::digit_char(top_dig), last: 1'b0};
                if (r_nd == NdW'(1)) begin
                    if (r_rpad && (r_pcnt != '0)) begin
                        n_state = i2a_pkg::S_RPAD;
                    end else begin
                        n_res.last = 1'b1;
                        n_state    = i2a_pkg::S_IDLE;
                    end
                end
            end
            i2a_pkg::S_RPAD: begin
                n_strobe = 1'b1;
                n_pcnt   = r_pcnt - PW'(1);
                n_res    = '{ch: r_pc, last: (r_pcnt == PW'(1))};
                if (r_pcnt == PW'(1)) begin
                    n_state = i2a_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = i2a_pkg::S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= i2a_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_bcnt   <= '0;
            r_nd     <= '0;
            r_pcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_bcnt   <= n_bcnt;
            r_nd     <= n_nd;
            r_pcnt   <= n_pcnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_dec  <= n_dec;
        r_lpad <= n_lpad;
        r_rpad <= n_rpad;
        r_pc   <= n_pc;
        r_p    <= n_p;
        r_res  <= n_res;
    end

    assign busy     = (r_state != i2a_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

`ifndef SYNTHESIS
    // A final character is never followed at once by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last) |=> !o_strobe)
        else $error("character right after last");

    // An accepted word always starts a conversion
    a_start_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == i2a_pkg::S_CONV))
        else $error("accepted word did not start conversion");

    // Alignment and digit output never run with an empty digit count
    a_digit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2a_pkg::S_DIGIT || r_state == i2a_pkg::S_ALIGN) |-> (r_nd != '0))
        else $error("digit count ran out");

    // Pad states always have characters left to send
    a_pad_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2a_pkg::S_LPAD || r_state == i2a_pkg::S_RPAD) |-> (r_pcnt != '0))
        else $error("pad count ran out");
`endif

endmodule

[rtl/i2a_cell.sv]
// ----------------------------------------------------------------------------
// i2a_cell: one digit cell of the conversion chain
// Holds one 4-bit digit. During conversion it applies the add-3 correction
// (decimal only) and shifts one bit in from the cell below; during output it
// takes the whole digit of the cell below.
// ----------------------------------------------------------------------------
module i2a_cell (
    input  logic              i_clk,
    input  i2a_pkg::t_cell_ctl i_ctl,
    input  logic              i_bit,
    input  logic [3:0]        i_dig,
    output logic              o_bit,
    output logic [3:0]        o_dig
);

    logic [3:0] r_dig;
    logic [3:0] n_dig;
    logic [3:0] adj;

    // In decimal mode, add 3 when the digit is 5 or more, so the shift carries at ten
    always_comb begin
        if (i_ctl.dec && (r_dig >= 4'd5)) begin
            adj = r_dig + 4'd3;
        end else begin
            adj = r_dig;
        end
    end

    // Next digit
    always_comb begin
        n_dig = r_dig;
        if (i_ctl.clr) begin
            n_dig = 4'd0;
        end else if (i_ctl.bit_shift) begin
            n_dig = {adj[2:0], i_bit};
        end else if (i_ctl.dig_shift) begin
            n_dig = i_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig <= n_dig;
    end

    assign o_bit = adj[3];
    assign o_dig = r_dig;

endmodule

[bench/ascii_text_checker.sv]
// ----------------------------------------------------------------------------
// ascii_text_checker: predicts and checks the printed text of each number
// Watches the command and character channels. Each accepted number is
// rendered into the characters it must produce, and each strobed character
// is compared with the oldest one still owed.
// ----------------------------------------------------------------------------
module ascii_text_checker #(
    parameter int PAD_LIMIT = i2a_pkg::PadLimitDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  i2a_pkg::t_in   i_item,
    input  logic           i_strobe,
    input  i2a_pkg::t_res  i_res,
    output int             o_fail_count,
    output int             o_chars_owed
);

    // Characters still owed by the block, oldest first
    i2a_pkg::t_res owed_text[$];
    int            fail_count = 0;

    assign o_fail_count = fail_count;

    // Render one number as padded text and queue its characters
    function automatic void render_number(input i2a_pkg::t_in w);
        logic [63:0]   mag;
        logic [63:0]   radix;
        logic [63:0]   d;
        logic          neg;
        logic [7:0]    digits[$];
        logic [7:0]    line[$];
        int            width;
        int            abs_w;
        int            fill;
        int            text_len;
        i2a_pkg::t_res r;

        mag = w.word_size ? w.value : {32'd0, w.value[31:0]};
        neg = 1'b0;

        // signed decimal: take the magnitude, the most negative value included
        if (w.func == i2a_pkg::FUNC_SDEC) begin
            if (w.word_size && mag[63]) begin
                neg = 1'b1;
                mag = 64'd0 - mag;
            end else if (!w.word_size && mag[31]) begin
                neg = 1'b1;
                mag = (64'd0 - mag) & 64'h0000_0000_ffff_ffff;
            end
        end

        // digits, most significant first; zero gives a single digit
        radix = (w.func == i2a_pkg::FUNC_HEX) ? 64'd16 : 64'd10;
        do begin
            d = mag % radix;
            if (d < 64'd10) digits.push_front(i2a_pkg::CHAR_ZERO + d[7:0]);
            else            digits.push_front(i2a_pkg::CHAR_A_LC + d[7:0] - 8'd10);
            mag = mag / radix;
        end while (mag != 64'd0);

        // field width, saturated
        width = int'($signed(w.pad_width));
        abs_w = (width < 0) ? -width : width;
        if (abs_w > PAD_LIMIT) abs_w = PAD_LIMIT;
        text_len = digits.size() + (neg ? 1 : 0);
        fill = (text_len < abs_w) ? abs_w - text_len : 0;

        // left pad goes before the sign, right pad after the last digit
        if (width > 0) repeat (fill) line.push_back(w.pad_char);
        if (neg) line.push_back(i2a_pkg::CHAR_MINUS);
        foreach (digits[k]) line.push_back(digits[k]);
        if (width < 0) repeat (fill) line.push_back(w.pad_char);

        foreach (line[k]) begin
            r.ch   = line[k];
            r.last = (k == line.size() - 1);
            owed_text.push_back(r);
        end
    endfunction

    // Count a failure; only the first few are printed
    task automatic note_fault(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR: %s", msg);
    endtask

    // Compare strobed characters first, then take in a new number
    always @(posedge i_clk) begin
        i2a_pkg::t_res want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (owed_text.size() == 0) begin
                    note_fault($sformatf("unexpected word: ch=%h last=%0b",
                                         i_res.ch, i_res.last));
                end else begin
                    want = owed_text.pop_front();
                    if (want.ch != i_res.ch || want.last != i_res.last) begin
                        note_fault($sformatf(
                            "word mismatch: expected ch=%h last=%0b, got ch=%h last=%0b",
                            want.ch, want.last, i_res.ch, i_res.last));
                    end
                end
            end
            if (i_start && !i_busy) render_number(i_item);
        end
        o_chars_owed <= owed_text.size();
    end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: integer to padded ASCII printer
// Drives directed corner numbers and then random ones, with random sender
// gaps and drain pauses, and leaves the checking to ascii_text_checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int StallLimit = 2000;
    localparam int RandomItems = 88;

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    i2a_pkg::t_in  i_item  = '0;
    logic          busy;
    logic          o_strobe;
    i2a_pkg::t_res o_res;

    int fail_count;
    int chars_owed;
    int stall_cycles = 0;
    bit steady = 1'b0;

    integer_to_ascii_padded u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    ascii_text_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_chars_owed (chars_owed)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: too long with no word moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= StallLimit) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    function automatic i2a_pkg::t_in number_word(input logic [1:0] func, input logic ws,
                                                 input logic [63:0] value,
                                                 input logic [7:0] pc, input int pw);
        i2a_pkg::t_in w;
        w.func      = func;
        w.word_size = ws;
        w.value     = value;
        w.pad_char  = pc;
        w.pad_width = pw[7:0];
        return w;
    endfunction

    // Values spread over the interesting ranges
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(1000));
            2: v = {32'hffff_ffff, $urandom};
            3: v = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
            4: v = {1'b1, 31'($urandom), $urandom};
            default: v = {$urandom, 1'b1, 31'($urandom)};
        endcase
        return v;
    endfunction

    function automatic i2a_pkg::t_in random_number();
        logic [1:0] func;
        int pw;
        func = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        case ($urandom_range(3))
            0: pw = 0;
            1: pw = $urandom_range(24) - 12;
            2: pw = $urandom_range(128) - 64;
            default: pw = $urandom_range(255) - 128;
        endcase
        return number_word(func, 1'($urandom), random_value(), 8'($urandom), pw);
    endfunction

    // Offer one word and hold it until accepted; entered on a rising edge
    task automatic send_word(input i2a_pkg::t_in w);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 28) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(20, 150)
                                           : $urandom_range(1, 6);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold off until every owed character has come out
    task automatic drain_pause();
        start <= 1'b0;
        @(posedge i_clk);
        while (chars_owed != 0) @(posedge i_clk);
    endtask

    // Stimulus and verdict
    initial begin
        i2a_pkg::t_in corner[$];

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero, full range, upper bits ignored in a narrow word
        corner.push_back(number_word(i2a_pkg::FUNC_UDEC, 1'b0, 64'd0, 8'h2a, 0));
        corner.push_back(number_word(i2a_pkg::FUNC_UDEC, 1'b1, '1, 8'h20, 0));
        corner.push_back(number_word(i2a_pkg::FUNC_UDEC, 1'b0, 64'h1234_5678_ffff_ffff,
                                     8'h20, 0));
        corner.push_back(number_word(i2a_pkg::FUNC_HEX, 1'b1, '1, 8'h20, 0));
        corner.push_back(number_word(i2a_pkg::FUNC_HEX, 1'b0, 64'habcd_0000_dead_beef,
                                     8'h30, 8));
        corner.push_back(number_word(i2a_pkg::FUNC_HEX, 1'b1, 64'd0, 8'h2e, -5));
        // most negative values print their full magnitude
        corner.push_back(number_word(i2a_pkg::FUNC_SDEC, 1'b0, 64'h0000_0000_8000_0000,
                                     8'h20, 0));
        corner.push_back(number_word(i2a_pkg::FUNC_SDEC, 1'b1, 64'h8000_0000_0000_0000,
                                     8'h20, 0));
        // left pad before the minus sign, right pad after the digits
        corner.push_back(number_word(i2a_pkg::FUNC_SDEC, 1'b0, '1, 8'h30, 6));
        corner.push_back(number_word(i2a_pkg::FUNC_SDEC, 1'b1, '1, 8'h5f, -6));
        corner.push_back(number_word(i2a_pkg::FUNC_SDEC, 1'b0, 64'h0000_0000_7fff_ffff,
                                     8'h20, 0));
        corner.push_back(number_word(i2a_pkg::FUNC_SDEC, 1'b1, 64'h7fff_ffff_ffff_ffff,
                                     8'h20, 0));
        corner.push_back(number_word(i2a_pkg::FUNC_SDEC, 1'b0, 64'hffff_ffff_0000_0001,
                                     8'h78, -1));
        // selector three prints unsigned decimal
        corner.push_back(number_word(2'd3, 1'b1, 64'hffff_ffff_ffff_fffe, 8'h20, 0));
        // widths at and past the limit
        corner.push_back(number_word(i2a_pkg::FUNC_UDEC, 1'b0, 64'd5, 8'h23, 64));
        corner.push_back(number_word(i2a_pkg::FUNC_UDEC, 1'b0, 64'd5, 8'h23, -64));
        corner.push_back(number_word(i2a_pkg::FUNC_HEX, 1'b0, 64'hff, 8'h78, 127));
        corner.push_back(number_word(i2a_pkg::FUNC_HEX, 1'b0, 64'hff, 8'h78, -128));
        corner.push_back(number_word(i2a_pkg::FUNC_UDEC, 1'b0, 64'd9, 8'h7a, 65));
        corner.push_back(number_word(i2a_pkg::FUNC_SDEC, 1'b1, 64'd0, 8'h79, -65));
        // width shorter than the text and one past it
        corner.push_back(number_word(i2a_pkg::FUNC_UDEC, 1'b1, 64'd12345, 8'h00, 1));
        corner.push_back(number_word(i2a_pkg::FUNC_UDEC, 1'b1, '1, 8'hff, 21));
        corner.push_back(number_word(i2a_pkg::FUNC_SDEC, 1'b1, 64'h8000_0000_0000_0000,
                                     8'h2b, -21));

        foreach (corner[k]) send_word(corner[k]);
        drain_pause();

        // random numbers, with a stretch of back-to-back offers in the middle
        for (int n = 0; n < RandomItems; n++) begin
            steady = (n >= 55 && n < 85);
            if (n == 40) drain_pause();
            send_word(random_number());
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (chars_owed != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
